### rtl/ssd_pkg.sv
`default_nettype none

package ssd_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int ParamBits  = 32;
  localparam int DistWidth  = 33;
  localparam int EpsRecip   = 10000;
  localparam int MulLat     = 5;
  localparam int DivLat     = ParamBits + 2;

  localparam logic [DistWidth-1:0] DistMax = '1;

  // degree of a quantity, used to pick the near-zero threshold
  typedef enum logic [1:0] {
    Deg0 = 2'd0,
    Deg2 = 2'd1,
    Deg4 = 2'd2
  } deg_e;

endpackage

`default_nettype wire

### rtl/ssd_dly.sv
`default_nettype none

module ssd_dly #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int i = 1; i < N; i++) begin
      sr_q[i] <= sr_q[i-1];
    end
  end

  assign q_o = sr_q[N-1];

endmodule

`default_nettype wire

### rtl/ssd_wmul.sv
`default_nettype none

module ssd_wmul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vld_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic                    vld_o,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int NA = (AW + 31) / 32;
  localparam int NB = (BW + 31) / 32;
  localparam int RW = 32 * (NB + 1);
  localparam int PW = 32 * (NA + NB);
  localparam int OW = AW + BW;
  localparam int ML = ssd_pkg::MulLat;

  logic [AW-1:0]      am;
  logic [BW-1:0]      bm;
  logic [32*NA-1:0]   ma_q;
  logic [32*NB-1:0]   mb_q;
  logic [63:0]        pp_q [NA][NB];
  logic [RW-1:0]      row_d [NA];
  logic [RW-1:0]      row_q [NA];
  logic [PW-1:0]      sum_d;
  logic [PW-1:0]      sum_q;
  logic signed [OW-1:0] p_q;
  logic [ML-1:0]      vld_q;
  logic [ML-1:0]      neg_q;

  // magnitudes, sign applied at the end
  assign am = a_i[AW-1] ? AW'(-a_i) : AW'(a_i);
  assign bm = b_i[BW-1] ? BW'(-b_i) : BW'(b_i);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (RW'(pp_q[i][j]) << (32 * j));
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      sum_d = sum_d + (PW'(row_q[i]) << (32 * i));
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q <= (32*NA)'(am);
    mb_q <= (32*NB)'(bm);
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_q[i][j] <= 64'(ma_q[32*i +: 32]) * 64'(mb_q[32*j +: 32]);
      end
      row_q[i] <= row_d[i];
    end
    sum_q <= sum_d;
    p_q   <= neg_q[ML-2] ? -OW'(sum_q) : OW'(sum_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      neg_q <= '0;
    end else begin
      vld_q <= {vld_q[ML-2:0], vld_i};
      neg_q <= {neg_q[ML-2:0], a_i[AW-1] ^ b_i[BW-1]};
    end
  end

  assign vld_o = vld_q[ML-1];
  assign p_o   = p_q;

endmodule

`default_nettype wire

### rtl/ssd_div.sv
`default_nettype none

module ssd_div #(
  parameter int W = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         vld_i,
  input  logic [W-1:0]                 num_i,
  input  logic [W-1:0]                 den_i,
  output logic                         vld_o,
  output logic [ssd_pkg::DivLat-1:0]   quo_o
);

  localparam int DL = ssd_pkg::DivLat;

  logic [W:0]    rem_s [DL+1];
  logic [W-1:0]  den_s [DL+1];
  logic [DL-1:0] quo_s [DL+1];
  logic          vld_s [DL+1];

  assign rem_s[0] = {1'b0, num_i};
  assign den_s[0] = den_i;
  assign quo_s[0] = '0;
  assign vld_s[0] = vld_i;

  for (genvar k = 0; k < DL; k++) begin : g_step
    logic       ge;
    logic [W:0] r1;

    assign ge = rem_s[k] >= {1'b0, den_s[k]};
    assign r1 = ge ? rem_s[k] - {1'b0, den_s[k]} : rem_s[k];

    always_ff @(posedge clk_i) begin
      rem_s[k+1] <= {r1[W-1:0], 1'b0};
      den_s[k+1] <= den_s[k];
      quo_s[k+1] <= {quo_s[k][DL-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= vld_s[k];
      end
    end
  end

  assign vld_o = vld_s[DL];
  assign quo_o = quo_s[DL];

endmodule

`default_nettype wire

### rtl/ssd_sqrt.sv
`default_nettype none

module ssd_sqrt #(
  parameter int W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  logic [W-1:0]     rad_i,
  output logic             vld_o,
  output logic [W/2-1:0]   root_o
);

  localparam int RW = W / 2;
  localparam int XW = RW + 3;

  logic [XW-1:0] rem_s  [RW+1];
  logic [RW-1:0] root_s [RW+1];
  logic [W-1:0]  rad_s  [RW+1];
  logic          vld_s  [RW+1];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = rad_i;
  assign vld_s[0]  = vld_i;

  // one root bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [XW-1:0] cur;
    logic [XW-1:0] trial;
    logic          ge;

    assign cur   = {rem_s[k][XW-3:0], rad_s[k][W-1:W-2]};
    assign trial = XW'({root_s[k], 2'b01});
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i) begin
      rem_s[k+1]  <= ge ? cur - trial : cur;
      root_s[k+1] <= {root_s[k][RW-2:0], ge};
      rad_s[k+1]  <= {rad_s[k][W-3:0], 2'b00};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= vld_s[k];
      end
    end
  end

  assign vld_o  = vld_s[RW];
  assign root_o = root_s[RW];

endmodule

`default_nettype wire

### rtl/segment_segment_distance.sv
`default_nettype none

// Closest distance between two 3D segments given as signed Q16.16 endpoints, result in
// unsigned Q17.16 saturated at 2^33-1. Fully pipelined: one segment pair may be started
// every clock cycle and busy_o is always low. The result appears on distance_o with
// done_o high for exactly one cycle; the receiver cannot stall it. The pipeline runs
// through the 34-stage restoring divider for the closest-point parameters and the
// bit-per-stage square root, whose depth grows with COORD_WIDTH, plus four chunked
// multiplier pipelines.
module segment_segment_distance #(
  parameter int COORD_WIDTH = ssd_pkg::CoordWidth,
  parameter int FRAC_BITS   = ssd_pkg::FracBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [COORD_WIDTH-1:0]     seg_a_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]     seg_a_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]     seg_a_start_z_i,
  input  logic signed [COORD_WIDTH-1:0]     seg_a_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]     seg_a_end_y_i,
  input  logic signed [COORD_WIDTH-1:0]     seg_a_end_z_i,
  input  logic signed [COORD_WIDTH-1:0]     seg_b_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]     seg_b_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]     seg_b_start_z_i,
  input  logic signed [COORD_WIDTH-1:0]     seg_b_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]     seg_b_end_y_i,
  input  logic signed [COORD_WIDTH-1:0]     seg_b_end_z_i,
  output logic [ssd_pkg::DistWidth-1:0]     distance_o,
  output logic                              done_o
);

  localparam int CW    = COORD_WIDTH;
  localparam int UW    = CW + 1;
  localparam int PUW   = 2 * UW;
  localparam int DW    = 2 * CW + 4;
  localparam int NW    = 2 * DW + 1;
  localparam int PB    = ssd_pkg::ParamBits;
  localparam int ML    = ssd_pkg::MulLat;
  localparam int DL    = ssd_pkg::DivLat;
  localparam int SCW   = PB + 1;
  localparam int SAW   = PB + 2;
  localparam int SPW   = SAW + UW;
  localparam int CP    = CW + 37;
  localparam int SQW   = 2 * CP;
  localparam int SW    = 2 * CP + 2;
  localparam int RW    = SW / 2;
  localparam int XW    = RW + PB + 2;
  localparam int TW    = NW + 4 * FRAC_BITS + 1;
  localparam int DlyUV = 6 + 2 * ML + DL;
  localparam int DlyW  = DlyUV + ML;

  localparam logic [TW-1:0] Thr2 =
    ((TW'(1) << (2 * FRAC_BITS)) - TW'(1)) / TW'(ssd_pkg::EpsRecip);
  localparam logic [TW-1:0] Thr4 =
    ((TW'(1) << (4 * FRAC_BITS)) - TW'(1)) / TW'(ssd_pkg::EpsRecip);

  typedef struct packed {
    logic signed [NW-1:0] sn;
    logic signed [NW-1:0] sd;
    logic signed [NW-1:0] tn;
    logic signed [NW-1:0] td;
    ssd_pkg::deg_e        sdeg;
    ssd_pkg::deg_e        tdeg;
  } par_t;

  function automatic logic is_small(input logic signed [NW-1:0] q, input ssd_pkg::deg_e dg);
    logic [TW-1:0] mag;
    logic [TW-1:0] thr;
    mag = TW'($unsigned(q[NW-1] ? -q : q));
    case (dg)
      ssd_pkg::Deg2: thr = Thr2;
      ssd_pkg::Deg4: thr = Thr4;
      default:       thr = '0;
    endcase
    return mag <= thr;
  endfunction

  // endpoint differences
  logic signed [CW-1:0] pa0 [3];
  logic signed [CW-1:0] pa1 [3];
  logic signed [CW-1:0] pb0 [3];
  logic signed [CW-1:0] pb1 [3];
  logic signed [UW-1:0] u_q [3];
  logic signed [UW-1:0] v_q [3];
  logic signed [UW-1:0] w_q [3];
  logic                 vld1_q;

  assign pa0[0] = seg_a_start_x_i;
  assign pa0[1] = seg_a_start_y_i;
  assign pa0[2] = seg_a_start_z_i;
  assign pa1[0] = seg_a_end_x_i;
  assign pa1[1] = seg_a_end_y_i;
  assign pa1[2] = seg_a_end_z_i;
  assign pb0[0] = seg_b_start_x_i;
  assign pb0[1] = seg_b_start_y_i;
  assign pb0[2] = seg_b_start_z_i;
  assign pb1[0] = seg_b_end_x_i;
  assign pb1[1] = seg_b_end_y_i;
  assign pb1[2] = seg_b_end_z_i;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      u_q[k] <= UW'(pa1[k]) - UW'(pa0[k]);
      v_q[k] <= UW'(pb1[k]) - UW'(pb0[k]);
      w_q[k] <= UW'(pa0[k]) - UW'(pb0[k]);
    end
  end

  // dot products
  logic signed [PUW-1:0] uu [3];
  logic signed [PUW-1:0] uv [3];
  logic signed [PUW-1:0] vv [3];
  logic signed [PUW-1:0] uw [3];
  logic signed [PUW-1:0] vw [3];
  logic                  dot_vld;

  for (genvar k = 0; k < 3; k++) begin : g_dot
    logic vld_uu;
    if (k == 0) begin : g_vld
      assign dot_vld = vld_uu;
    end
    ssd_wmul #(.AW(UW), .BW(UW)) u_uu (
      .clk_i, .rst_ni, .vld_i(vld1_q), .a_i(u_q[k]), .b_i(u_q[k]),
      .vld_o(vld_uu), .p_o(uu[k]));
    ssd_wmul #(.AW(UW), .BW(UW)) u_uv (
      .clk_i, .rst_ni, .vld_i(vld1_q), .a_i(u_q[k]), .b_i(v_q[k]),
      .vld_o(), .p_o(uv[k]));
    ssd_wmul #(.AW(UW), .BW(UW)) u_vv (
      .clk_i, .rst_ni, .vld_i(vld1_q), .a_i(v_q[k]), .b_i(v_q[k]),
      .vld_o(), .p_o(vv[k]));
    ssd_wmul #(.AW(UW), .BW(UW)) u_uw (
      .clk_i, .rst_ni, .vld_i(vld1_q), .a_i(u_q[k]), .b_i(w_q[k]),
      .vld_o(), .p_o(uw[k]));
    ssd_wmul #(.AW(UW), .BW(UW)) u_vw (
      .clk_i, .rst_ni, .vld_i(vld1_q), .a_i(v_q[k]), .b_i(w_q[k]),
      .vld_o(), .p_o(vw[k]));
  end

  logic signed [DW-1:0] a_q, b_q, c_q, d_q, e_q;
  logic                 sum1_vld_q;

  always_ff @(posedge clk_i) begin
    a_q <= DW'(uu[0]) + DW'(uu[1]) + DW'(uu[2]);
    b_q <= DW'(uv[0]) + DW'(uv[1]) + DW'(uv[2]);
    c_q <= DW'(vv[0]) + DW'(vv[1]) + DW'(vv[2]);
    d_q <= DW'(uw[0]) + DW'(uw[1]) + DW'(uw[2]);
    e_q <= DW'(vw[0]) + DW'(vw[1]) + DW'(vw[2]);
  end

  // determinant and numerators
  logic signed [2*DW-1:0] m_ac, m_bb, m_be, m_cd, m_ae, m_bd;
  logic                   mul2_vld;

  ssd_wmul #(.AW(DW), .BW(DW)) u_ac (
    .clk_i, .rst_ni, .vld_i(sum1_vld_q), .a_i(a_q), .b_i(c_q), .vld_o(mul2_vld), .p_o(m_ac));
  ssd_wmul #(.AW(DW), .BW(DW)) u_bb (
    .clk_i, .rst_ni, .vld_i(sum1_vld_q), .a_i(b_q), .b_i(b_q), .vld_o(), .p_o(m_bb));
  ssd_wmul #(.AW(DW), .BW(DW)) u_be (
    .clk_i, .rst_ni, .vld_i(sum1_vld_q), .a_i(b_q), .b_i(e_q), .vld_o(), .p_o(m_be));
  ssd_wmul #(.AW(DW), .BW(DW)) u_cd (
    .clk_i, .rst_ni, .vld_i(sum1_vld_q), .a_i(c_q), .b_i(d_q), .vld_o(), .p_o(m_cd));
  ssd_wmul #(.AW(DW), .BW(DW)) u_ae (
    .clk_i, .rst_ni, .vld_i(sum1_vld_q), .a_i(a_q), .b_i(e_q), .vld_o(), .p_o(m_ae));
  ssd_wmul #(.AW(DW), .BW(DW)) u_bd (
    .clk_i, .rst_ni, .vld_i(sum1_vld_q), .a_i(b_q), .b_i(d_q), .vld_o(), .p_o(m_bd));

  logic [5*DW-1:0] dots_dly;

  ssd_dly #(.W(5 * DW), .N(ML)) u_dots_dly (
    .clk_i, .d_i({e_q, d_q, c_q, b_q, a_q}), .q_o(dots_dly));

  logic signed [NW-1:0] dd_q, sn0_q, tn0_q;
  logic signed [DW-1:0] a2_q, b2_q, c2_q, d2_q, e2_q;
  logic                 dd_vld_q;

  always_ff @(posedge clk_i) begin
    dd_q  <= NW'(m_ac) - NW'(m_bb);
    sn0_q <= NW'(m_be) - NW'(m_cd);
    tn0_q <= NW'(m_ae) - NW'(m_bd);
    a2_q  <= dots_dly[0*DW +: DW];
    b2_q  <= dots_dly[1*DW +: DW];
    c2_q  <= dots_dly[2*DW +: DW];
    d2_q  <= dots_dly[3*DW +: DW];
    e2_q  <= dots_dly[4*DW +: DW];
  end

  // parameter selection on the infinite lines, s clamped to its segment, near-parallel case s = 0
  par_t                 p1_d, p1_q;
  logic signed [DW-1:0] a3_q, b3_q, d3_q;
  logic                 p1_vld_q;

  always_comb begin
    p1_d.sn   = sn0_q;
    p1_d.sd   = dd_q;
    p1_d.sdeg = ssd_pkg::Deg4;
    p1_d.tn   = tn0_q;
    p1_d.td   = dd_q;
    p1_d.tdeg = ssd_pkg::Deg4;
    if (is_small(dd_q, ssd_pkg::Deg4)) begin
      p1_d.sn   = '0;
      p1_d.sd   = NW'(1);
      p1_d.sdeg = ssd_pkg::Deg0;
      p1_d.tn   = NW'(e2_q);
      p1_d.td   = NW'(c2_q);
      p1_d.tdeg = ssd_pkg::Deg2;
    end else if (sn0_q[NW-1]) begin
      p1_d.sn   = '0;
      p1_d.tn   = NW'(e2_q);
      p1_d.td   = NW'(c2_q);
      p1_d.tdeg = ssd_pkg::Deg2;
    end else if (sn0_q > dd_q) begin
      p1_d.sn   = dd_q;
      p1_d.tn   = NW'(e2_q) + NW'(b2_q);
      p1_d.td   = NW'(c2_q);
      p1_d.tdeg = ssd_pkg::Deg2;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q <= p1_d;
    a3_q <= a2_q;
    b3_q <= b2_q;
    d3_q <= d2_q;
  end

  // clamp t and recompute s on its edge
  par_t                 p2_d, p2_q;
  logic signed [NW-1:0] m;
  logic                 p2_vld_q;

  assign m = p1_q.tn[NW-1] ? -NW'(d3_q) : NW'(b3_q) - NW'(d3_q);

  always_comb begin
    p2_d = p1_q;
    if (p1_q.tn[NW-1] || (p1_q.tn > p1_q.td)) begin
      p2_d.tn = p1_q.tn[NW-1] ? '0 : p1_q.td;
      if (m[NW-1]) begin
        p2_d.sn = '0;
      end else if (m > NW'(a3_q)) begin
        p2_d.sn = p1_q.sd;
      end else begin
        p2_d.sn   = m;
        p2_d.sd   = NW'(a3_q);
        p2_d.sdeg = ssd_pkg::Deg2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p2_q <= p2_d;
  end

  // near-zero numerators and zero or negative denominators divide as 0/1
  logic [NW-1:0] sdiv_num_q, sdiv_den_q, tdiv_num_q, tdiv_den_q;
  logic          zs, zt;
  logic          p3_vld_q;

  assign zs = is_small(p2_q.sn, p2_q.sdeg) || p2_q.sd[NW-1] || (p2_q.sd == '0);
  assign zt = is_small(p2_q.tn, p2_q.tdeg) || p2_q.td[NW-1] || (p2_q.td == '0);

  always_ff @(posedge clk_i) begin
    sdiv_num_q <= zs ? '0 : $unsigned(p2_q.sn);
    sdiv_den_q <= zs ? NW'(1) : $unsigned(p2_q.sd);
    tdiv_num_q <= zt ? '0 : $unsigned(p2_q.tn);
    tdiv_den_q <= zt ? NW'(1) : $unsigned(p2_q.td);
  end

  logic [DL-1:0] squo, tquo;
  logic          div_vld;

  ssd_div #(.W(NW)) u_sdiv (
    .clk_i, .rst_ni, .vld_i(p3_vld_q), .num_i(sdiv_num_q), .den_i(sdiv_den_q),
    .vld_o(div_vld), .quo_o(squo));
  ssd_div #(.W(NW)) u_tdiv (
    .clk_i, .rst_ni, .vld_i(p3_vld_q), .num_i(tdiv_num_q), .den_i(tdiv_den_q),
    .vld_o(), .quo_o(tquo));

  logic [SCW-1:0] sc_q, tc_q;
  logic           rnd_vld_q;

  always_ff @(posedge clk_i) begin
    sc_q <= SCW'(({1'b0, squo} + (DL+1)'(1)) >> 1);
    tc_q <= SCW'(({1'b0, tquo} + (DL+1)'(1)) >> 1);
  end

  // closest-point offset w + s*u - t*v
  logic [6*UW-1:0] uv_dly;
  logic [3*UW-1:0] w_dly;

  ssd_dly #(.W(6 * UW), .N(DlyUV)) u_uv_dly (
    .clk_i, .d_i({v_q[2], v_q[1], v_q[0], u_q[2], u_q[1], u_q[0]}), .q_o(uv_dly));
  ssd_dly #(.W(3 * UW), .N(DlyW)) u_w_dly (
    .clk_i, .d_i({w_q[2], w_q[1], w_q[0]}), .q_o(w_dly));

  logic signed [SPW-1:0] su [3];
  logic signed [SPW-1:0] tv [3];
  logic signed [CP-1:0]  comp_q [3];
  logic signed [SQW-1:0] sq [3];
  logic                  st_vld, sq_vld;
  logic                  comp_vld_q;

  for (genvar k = 0; k < 3; k++) begin : g_comp
    logic signed [UW-1:0] uk, vk, wk;
    logic                 vld_su;

    assign uk = uv_dly[k*UW +: UW];
    assign vk = uv_dly[(3+k)*UW +: UW];
    assign wk = w_dly[k*UW +: UW];
    if (k == 0) begin : g_vld
      assign st_vld = vld_su;
    end

    ssd_wmul #(.AW(SAW), .BW(UW)) u_su (
      .clk_i, .rst_ni, .vld_i(rnd_vld_q), .a_i($signed({1'b0, sc_q})), .b_i(uk),
      .vld_o(vld_su), .p_o(su[k]));
    ssd_wmul #(.AW(SAW), .BW(UW)) u_tv (
      .clk_i, .rst_ni, .vld_i(rnd_vld_q), .a_i($signed({1'b0, tc_q})), .b_i(vk),
      .vld_o(), .p_o(tv[k]));

    always_ff @(posedge clk_i) begin
      comp_q[k] <= (CP'(wk) <<< PB) + CP'(su[k]) - CP'(tv[k]);
    end
  end

  ssd_wmul #(.AW(CP), .BW(CP)) u_sq0 (
    .clk_i, .rst_ni, .vld_i(comp_vld_q), .a_i(comp_q[0]), .b_i(comp_q[0]),
    .vld_o(sq_vld), .p_o(sq[0]));
  ssd_wmul #(.AW(CP), .BW(CP)) u_sq1 (
    .clk_i, .rst_ni, .vld_i(comp_vld_q), .a_i(comp_q[1]), .b_i(comp_q[1]),
    .vld_o(), .p_o(sq[1]));
  ssd_wmul #(.AW(CP), .BW(CP)) u_sq2 (
    .clk_i, .rst_ni, .vld_i(comp_vld_q), .a_i(comp_q[2]), .b_i(comp_q[2]),
    .vld_o(), .p_o(sq[2]));

  logic [SW-1:0] dsq_q;
  logic          dsq_vld_q;

  always_ff @(posedge clk_i) begin
    dsq_q <= SW'($unsigned(sq[0])) + SW'($unsigned(sq[1])) + SW'($unsigned(sq[2]));
  end

  logic [RW-1:0] root;
  logic          root_vld;

  ssd_sqrt #(.W(SW)) u_sqrt (
    .clk_i, .rst_ni, .vld_i(dsq_vld_q), .rad_i(dsq_q), .vld_o(root_vld), .root_o(root));

  logic [XW-1:0]                  rnd;
  logic [XW-1:0]                  rsh;
  logic [ssd_pkg::DistWidth-1:0]  dist_q;
  logic                           done_q;

  assign rnd = XW'(root) + (XW'(1) << (PB - 1));
  assign rsh = rnd >> PB;

  always_ff @(posedge clk_i) begin
    dist_q <= (rsh > XW'(ssd_pkg::DistMax)) ? ssd_pkg::DistMax
                                            : rsh[ssd_pkg::DistWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q     <= 1'b0;
      sum1_vld_q <= 1'b0;
      dd_vld_q   <= 1'b0;
      p1_vld_q   <= 1'b0;
      p2_vld_q   <= 1'b0;
      p3_vld_q   <= 1'b0;
      rnd_vld_q  <= 1'b0;
      comp_vld_q <= 1'b0;
      dsq_vld_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      vld1_q     <= start_i && !busy_o;
      sum1_vld_q <= dot_vld;
      dd_vld_q   <= mul2_vld;
      p1_vld_q   <= dd_vld_q;
      p2_vld_q   <= p1_vld_q;
      p3_vld_q   <= p2_vld_q;
      rnd_vld_q  <= div_vld;
      comp_vld_q <= st_vld;
      dsq_vld_q  <= sq_vld;
      done_q     <= root_vld;
    end
  end

  assign distance_o = dist_q;
  assign done_o     = done_q;

  // t lies on the segment once clamped, s is never negative
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_vld_q |-> (!p2_q.tn[NW-1] && (p2_q.tn <= p2_q.td) && !p2_q.sn[NW-1]))
    else $error("clamped parameter out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p3_vld_q |-> ((sdiv_num_q <= sdiv_den_q) && (tdiv_num_q <= tdiv_den_q)
                  && (sdiv_den_q != '0) && (tdiv_den_q != '0)))
    else $error("divider operands out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_vld_q |-> ((sc_q <= (SCW'(1) << PB)) && (tc_q <= (SCW'(1) << PB))))
    else $error("rounded parameter above one");

endmodule

`default_nettype wire
